[hw/rtl/wse_pkg.sv]
// Shared types, constants and helpers for the 3x3 window sum extremum search.
// No dependencies; every module of the block imports this package.
package wse_pkg;

   // Matrix size limits
   localparam int MAX_COLS = 32;
   localparam int MAX_ROWS = 32;

   // Field and internal widths
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CFG_W  = 6;
   localparam int PIX_W  = 8;
   localparam int VERT_W = 10;
   localparam int SUM_W  = 12;
   localparam int IDX_W  = 2;

   // Smallest usable count, and the offset from bottom-right to top-left
   localparam int MIN_COUNT  = 3;
   localparam int WIN_OFFSET = 2;

   // Register indexes of the configuration port
   typedef enum logic [IDX_W-1:0] {
      CSR_ROW_COUNT     = 2'd0,
      CSR_COL_COUNT     = 2'd1,
      CSR_FIND_SMALLEST = 2'd2
   } csr_idx_type;

   // Raster position of the current beat and what it completes
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             in_window;
      logic             row_end;
      logic             frame_end;
   } pos_type;

   // Best window so far
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [ROW_W-1:0] top;
      logic [COL_W-1:0] left;
   } best_type;

   // Limit a configured count to the usable range
   function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
      logic [CFG_W-1:0] r;
      if (v < CFG_W'(MIN_COUNT)) begin
         r = CFG_W'(MIN_COUNT);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[hw/rtl/wse_position.sv]
// Row and column counters of the pixel raster, with row and frame end flags.
// Depends on wse_pkg.
module wse_position import wse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [CFG_W-1:0] row_count,
   input  logic [CFG_W-1:0] col_count,
   output pos_type          pos
);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CFG_W-1:0] rows, cols;
   logic             row_end, frame_end;

   // End of row / end of frame against the clamped counts
   always_comb begin
      rows      = clamp_count(row_count, CFG_W'(MAX_ROWS));
      cols      = clamp_count(col_count, CFG_W'(MAX_COLS));
      row_end   = (CFG_W'(col_ff) + CFG_W'(1)) >= cols;
      frame_end = row_end && ((CFG_W'(row_ff) + CFG_W'(1)) >= rows);
   end

   // Next position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (frame_end) begin
            row_in = '0;
            col_in = '0;
         end else if (row_end) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign pos.row       = row_ff;
   assign pos.col       = col_ff;
   assign pos.in_window = (row_ff >= ROW_W'(WIN_OFFSET)) && (col_ff >= COL_W'(WIN_OFFSET));
   assign pos.row_end   = row_end;
   assign pos.frame_end = frame_end;

endmodule

[hw/rtl/wse_line_buf.sv]
// Two line stores holding the previous two rows, and the vertical 3-pixel sum.
// Depends on wse_pkg.
module wse_line_buf import wse_pkg::*; (
   input  logic              clock,
   input  logic              accept,
   input  logic [COL_W-1:0]  col,
   input  logic [PIX_W-1:0]  pixel,
   output logic [VERT_W-1:0] vert
);

   logic [PIX_W-1:0] older_ff [MAX_COLS];
   logic [PIX_W-1:0] newer_ff [MAX_COLS];

   // Column of the two rows above plus the new pixel
   assign vert = VERT_W'(older_ff[col]) + VERT_W'(newer_ff[col]) + VERT_W'(pixel);

   // Shift the column down one row on each beat
   always_ff @(posedge clock) begin
      if (accept) begin
         older_ff[col] <= newer_ff[col];
         newer_ff[col] <= pixel;
      end
   end

endmodule

[hw/rtl/wse_best.sv]
// Running column sums, 3x3 window sum and best-window tracking.
// Depends on wse_pkg.
module wse_best import wse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pos_type           pos,
   input  logic [VERT_W-1:0] vert,
   input  logic              find_smallest,
   output best_type          best_next
);

   // Vertical sums of the two previous columns (older, newer)
   logic [VERT_W-1:0] col_a_ff, col_a_in;
   logic [VERT_W-1:0] col_b_ff, col_b_in;
   best_type          best_ff;
   logic              have_ff, have_in;
   logic [SUM_W-1:0]  win_sum;
   logic              better, take;

   // Window sum and compare against the best so far
   always_comb begin
      win_sum = SUM_W'(col_a_ff) + SUM_W'(col_b_ff) + SUM_W'(vert);
      better  = find_smallest ? (win_sum < best_ff.sum) : (win_sum > best_ff.sum);
      take    = pos.in_window && (!have_ff || better);
   end

   always_comb begin
      best_next = best_ff;
      have_in   = have_ff;
      if (take) begin
         best_next.sum  = win_sum;
         best_next.top  = pos.row - ROW_W'(WIN_OFFSET);
         best_next.left = pos.col - COL_W'(WIN_OFFSET);
         have_in        = 1'b1;
      end
   end

   // Column sums restart on every row
   always_comb begin
      col_a_in = col_a_ff;
      col_b_in = col_b_ff;
      if (accept) begin
         if (pos.row_end) begin
            col_a_in = '0;
            col_b_in = '0;
         end else begin
            col_a_in = col_b_ff;
            col_b_in = vert;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_a_ff <= '0;
         col_b_ff <= '0;
         best_ff  <= '0;
         have_ff  <= 1'b0;
      end else begin
         col_a_ff <= col_a_in;
         col_b_ff <= col_b_in;
         if (accept) begin
            if (pos.frame_end) begin
               best_ff <= '0;
               have_ff <= 1'b0;
            end else begin
               best_ff <= best_next;
               have_ff <= have_in;
            end
         end
      end
   end

endmodule

[hw/rtl/window_sum_extremum_search.sv]
// The result is registered onto rsp_* in the cycle after the frame's last pixel beat.
// Throughput: one pixel per cycle; all per-pixel work is done in the accepting cycle.
// The last pixel of a frame waits while the previous result is still held in the
// output register; no other pixel ever waits.
// Reset (synchronous, active high): counts 3x3, largest-sum search, frame state cleared.
module window_sum_extremum_search import wse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // pixel input
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_pixel,
   // result output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SUM_W-1:0] rsp_best_sum,
   output logic [ROW_W-1:0] rsp_best_row,
   output logic [COL_W-1:0] rsp_best_col,
   // configuration
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0]  row_count_ff, col_count_ff;
   logic              find_smallest_ff;
   logic              accept;
   pos_type           pos;
   logic [VERT_W-1:0] vert;
   best_type          best_next;
   logic              rsp_valid_ff;
   best_type          rsp_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= CFG_W'(MIN_COUNT);
         col_count_ff     <= CFG_W'(MIN_COUNT);
         find_smallest_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ROW_COUNT:     row_count_ff     <= csr_data;
            CSR_COL_COUNT:     col_count_ff     <= csr_data;
            CSR_FIND_SMALLEST: find_smallest_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Hold the frame's last beat while the previous result is unread
   assign req_stall = rsp_valid_ff && pos.frame_end;
   assign accept    = req_valid && !req_stall;

   wse_position u_position (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .pos       (pos)
   );

   wse_line_buf u_line_buf (
      .clock  (clock),
      .accept (accept),
      .col    (pos.col),
      .pixel  (req_pixel),
      .vert   (vert)
   );

   wse_best u_best (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .pos           (pos),
      .vert          (vert),
      .find_smallest (find_smallest_ff),
      .best_next     (best_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && pos.frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos.frame_end) begin
         rsp_ff <= best_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = rsp_ff.sum;
   assign rsp_best_row = rsp_ff.top;
   assign rsp_best_col = rsp_ff.left;

endmodule
